/* hdl/msd_pkg.sv */
package msd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned SLOTS_W    = 5;
  localparam int unsigned SLOT_CMP_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND    = 2'd0,
    CMD_URGENT  = 2'd1,
    CMD_GET     = 2'd2,
    CMD_GET_LEN = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_BYTES   = 1'b0,
    REG_SLOTS_IN_USE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_BYTES
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              end_of_message;
    logic [LEN_W-1:0]  max_len;
  } msd_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              out_last;
    logic [LEN_W-1:0]  stored_len;
    logic [LEN_W-1:0]  copied_len;
  } msd_out_t;

  typedef struct packed {
    logic take_item;
    logic eval_len;
    logic read_byte;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_get;
    logic single;
    logic last_byte;
  } dp_status_t;

endpackage

/* hdl/msd_ctrl.sv */
module msd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  msd_pkg::dp_status_t status_i,
  output msd_pkg::ctrl_cmd_t  ctrl_o,
  output logic                busy_o
);
  import msd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o           = 1'b0;
        ctrl_o.take_item = start_i;
        if (start_i && status_i.is_get) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        ctrl_o.eval_len = 1'b1;
        state_d         = status_i.single ? ST_IDLE : ST_BYTES;
      end
      ST_BYTES: begin
        ctrl_o.read_byte = 1'b1;
        if (status_i.last_byte) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/msd_datapath.sv */
module msd_datapath #(
  parameter int unsigned MAX_SLOTS      = 16,
  parameter int unsigned MAX_SLOT_BYTES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  msd_pkg::msd_in_t                    item_i,
  input  logic                                cfg_valid_i,
  input  logic [msd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [msd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  msd_pkg::ctrl_cmd_t                  ctrl_i,
  output msd_pkg::dp_status_t                 status_o,
  output msd_pkg::msd_out_t                   result_o,
  output logic                                strobe_o
);
  import msd_pkg::*;

  localparam int unsigned SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned BW    = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1;
  localparam int unsigned AW    = SW + BW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned LDEPTH = 1 << SW;

  logic [BYTE_W-1:0]  slot_mem [DEPTH];
  logic [LEN_W-1:0]   len_mem  [LDEPTH];

  logic [LEN_W-1:0]   slot_bytes_q;
  logic [SLOTS_W-1:0] slots_in_use_q;
  logic [SW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [LEN_W-1:0]   tail_fill_q, tail_fill_d, urgent_fill_q, urgent_fill_d;
  logic               urgent_active_q, urgent_active_d;
  logic [LEN_W-1:0]   maxl_q, stored_q, copied_q, k_q;
  logic               get_len_q;
  logic [BYTE_W-1:0]  slot_rd_q;
  logic [LEN_W-1:0]   len_rd_q;
  logic               strobe_q, oval_q, olast_q;
  logic               strobe_d, oval_d, olast_d;

  logic [LEN_W-1:0]   eff_bytes;
  logic [SW-1:0]      eff_m1;
  logic [SW-1:0]      wr_slot;
  logic [LEN_W-1:0]   wr_fill, new_fill;
  logic               room, wr_en, len_wr_en;
  logic [LEN_W-1:0]   stored, copied;
  logic               is_send, is_urgent;

  function automatic logic [SW-1:0] next_slot(logic [SW-1:0] s, logic [SW-1:0] m1);
    logic [SW-1:0] r;
    r = (s >= m1) ? '0 : SW'(s + 1'b1);
    return r;
  endfunction

  always_comb begin
    if (slot_bytes_q == '0) begin
      eff_bytes = LEN_W'(1);
    end else if (slot_bytes_q > LEN_W'(MAX_SLOT_BYTES)) begin
      eff_bytes = LEN_W'(MAX_SLOT_BYTES);
    end else begin
      eff_bytes = slot_bytes_q;
    end
    if (slots_in_use_q == '0) begin
      eff_m1 = '0;
    end else if (SLOT_CMP_W'(slots_in_use_q) > SLOT_CMP_W'(MAX_SLOTS)) begin
      eff_m1 = SW'(MAX_SLOTS - 1);
    end else begin
      eff_m1 = SW'(slots_in_use_q - 1'b1);
    end
  end

  assign is_send   = ctrl_i.take_item && (item_i.command == CMD_SEND);
  assign is_urgent = ctrl_i.take_item && (item_i.command == CMD_URGENT);

  always_comb begin
    head_d          = head_q;
    tail_d          = tail_q;
    tail_fill_d     = tail_fill_q;
    urgent_fill_d   = urgent_fill_q;
    urgent_active_d = urgent_active_q;
    if (is_urgent) begin
      wr_slot = urgent_active_q ? head_q : ((head_q == '0) ? eff_m1 : SW'(head_q - 1'b1));
      wr_fill = urgent_active_q ? urgent_fill_q : '0;
    end else begin
      wr_slot = tail_q;
      wr_fill = tail_fill_q;
    end
    room      = (wr_fill < eff_bytes);
    wr_en     = (is_send || is_urgent) && item_i.data_valid && room;
    new_fill  = (item_i.data_valid) ? (room ? LEN_W'(wr_fill + 1'b1) : eff_bytes) : wr_fill;
    len_wr_en = (is_send || is_urgent) && item_i.end_of_message;

    if (is_send) begin
      tail_fill_d = item_i.end_of_message ? '0 : new_fill;
      if (item_i.end_of_message) begin
        tail_d = next_slot(tail_q, eff_m1);
      end
    end
    if (is_urgent) begin
      head_d          = wr_slot;
      urgent_fill_d   = item_i.end_of_message ? '0 : new_fill;
      urgent_active_d = !item_i.end_of_message;
    end

    if ((ctrl_i.eval_len && status_o.single && !get_len_q) ||
        (ctrl_i.read_byte && status_o.last_byte)) begin
      head_d = next_slot(head_q, eff_m1);
    end
  end

  always_comb begin
    stored = (len_rd_q > LEN_W'(MAX_SLOT_BYTES)) ? LEN_W'(MAX_SLOT_BYTES) : len_rd_q;
    copied = (maxl_q < stored) ? maxl_q : stored;
    status_o.is_get    = (item_i.command == CMD_GET) || (item_i.command == CMD_GET_LEN);
    status_o.single    = get_len_q || (copied == '0);
    status_o.last_byte = (LEN_W'(k_q + 1'b1) == copied_q);
  end

  always_comb begin
    strobe_d = 1'b0;
    oval_d   = oval_q;
    olast_d  = olast_q;
    if (ctrl_i.eval_len && status_o.single) begin
      strobe_d = 1'b1;
      oval_d   = 1'b0;
      olast_d  = 1'b1;
    end else if (ctrl_i.read_byte) begin
      strobe_d = 1'b1;
      oval_d   = 1'b1;
      olast_d  = status_o.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_bytes_q    <= LEN_W'(64);
      slots_in_use_q  <= SLOTS_W'(16);
      head_q          <= '0;
      tail_q          <= '0;
      tail_fill_q     <= '0;
      urgent_fill_q   <= '0;
      urgent_active_q <= 1'b0;
      strobe_q        <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_SLOT_BYTES:   slot_bytes_q   <= cfg_data_i;
          REG_SLOTS_IN_USE: slots_in_use_q <= cfg_data_i[SLOTS_W-1:0];
        endcase
      end
      head_q          <= head_d;
      tail_q          <= tail_d;
      tail_fill_q     <= tail_fill_d;
      urgent_fill_q   <= urgent_fill_d;
      urgent_active_q <= urgent_active_d;
      strobe_q        <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oval_q  <= oval_d;
    olast_q <= olast_d;
    if (ctrl_i.take_item) begin
      maxl_q    <= item_i.max_len;
      get_len_q <= (item_i.command == CMD_GET_LEN);
    end
    if (ctrl_i.eval_len) begin
      stored_q <= stored;
      copied_q <= copied;
      k_q      <= '0;
    end else if (ctrl_i.read_byte) begin
      k_q <= LEN_W'(k_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[{wr_slot, wr_fill[BW-1:0]}] <= item_i.data_byte;
    end
    slot_rd_q <= slot_mem[{head_q, k_q[BW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (len_wr_en) begin
      len_mem[wr_slot] <= new_fill;
    end
    len_rd_q <= len_mem[head_q];
  end

  assign result_o.out_byte   = oval_q ? slot_rd_q : '0;
  assign result_o.out_valid  = oval_q;
  assign result_o.out_last   = olast_q;
  assign result_o.stored_len = stored_q;
  assign result_o.copied_len = copied_q;
  assign strobe_o            = strobe_q;

endmodule

/* hdl/message_slot_deque_top.sv */
// Message slot queue: a ring of fixed-size slots holding byte messages.
// An item is taken on a rising edge with start high and busy low. Send and
// urgent send items carry at most one byte each and finish in the cycle they
// are taken, so bytes may stream in back to back. A get or get length item
// raises busy. A get length, or a get whose copied length is zero, gives one
// result, registered from the length state, and then returns to idle. A get
// with a nonzero copied length first reads the length memory, then reads the
// slot memory one byte a cycle, and each byte appears on result_o with
// strobe_o high in the cycle after its read. The single read port of the slot
// memory sets this one byte per cycle. Each result is shown for exactly one
// cycle and the receiver cannot stall it. The configuration channel is
// always ready and should only be written while the block is idle. Reset
// clears the pointers, fill counts and urgent flag and restores the
// configuration registers to 64 bytes per slot and 16 slots; the message
// memories are not cleared and must be written before they are read.
module message_slot_deque_top #(
  parameter int unsigned MAX_SLOTS      = 16,
  parameter int unsigned MAX_SLOT_BYTES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  msd_pkg::msd_in_t               item_i,
  output msd_pkg::msd_out_t              result_o,
  output logic                           strobe_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [msd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [msd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import msd_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  msd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  msd_datapath #(
    .MAX_SLOTS      (MAX_SLOTS),
    .MAX_SLOT_BYTES (MAX_SLOT_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .result_o    (result_o),
    .strobe_o    (strobe_o)
  );

endmodule

/* bench/message_slot_deque_top_tb.sv */
module message_slot_deque_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msd_pkg::*;

  localparam int unsigned RING_MAX    = 16;
  localparam int unsigned CAP_MAX     = 64;
  localparam int unsigned STALL_LIMIT = 2000;

  class deque_scoreboard;
    logic [BYTE_W-1:0] slot_mem [RING_MAX][CAP_MAX];
    bit                slot_seen [RING_MAX][CAP_MAX];
    logic [LEN_W-1:0]  len_mem [RING_MAX];
    bit                len_seen [RING_MAX];
    int unsigned       head_ptr;
    int unsigned       tail_ptr;
    int unsigned       tail_count;
    int unsigned       urgent_count;
    bit                urgent_open;
    int unsigned       cap_reg;
    int unsigned       ring_reg;
    msd_out_t          due_results [$];
    int unsigned       failures;

    function new();
      head_ptr     = 0;
      tail_ptr     = 0;
      tail_count   = 0;
      urgent_count = 0;
      urgent_open  = 1'b0;
      cap_reg      = CAP_MAX;
      ring_reg     = RING_MAX;
      failures     = 0;
      foreach (len_seen[i]) len_seen[i] = 1'b0;
      foreach (slot_seen[i, j]) slot_seen[i][j] = 1'b0;
    endfunction

    function int unsigned eff_cap();
      if (cap_reg == 0) return 1;
      if (cap_reg > CAP_MAX) return CAP_MAX;
      return cap_reg;
    endfunction

    function int unsigned eff_ring();
      if (ring_reg == 0) return 1;
      if (ring_reg > RING_MAX) return RING_MAX;
      return ring_reg;
    endfunction

    function int unsigned step_fwd(int unsigned s);
      return (s + 1 >= eff_ring()) ? 0 : s + 1;
    endfunction

    function int unsigned step_back(int unsigned s);
      return (s == 0) ? eff_ring() - 1 : s - 1;
    endfunction

    function int unsigned readable_prefix(int unsigned slot);
      int unsigned n;
      n = 0;
      while (n < CAP_MAX && slot_seen[slot][n]) n++;
      return n;
    endfunction

    function int unsigned store_byte(int unsigned slot, int unsigned count,
                                     logic [BYTE_W-1:0] b);
      int unsigned cap;
      cap = eff_cap();
      if (count < cap) begin
        slot_mem[slot][count]  = b;
        slot_seen[slot][count] = 1'b1;
        count++;
      end
      return (count > cap) ? cap : count;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_SLOT_BYTES) begin
        cap_reg = val;
      end else begin
        ring_reg = val[SLOTS_W-1:0];
      end
    endfunction

    function void apply_command(msd_in_t it);
      int unsigned h;
      int unsigned t;
      int unsigned stored;
      int unsigned copied;
      msd_out_t    r;
      h = head_ptr % RING_MAX;
      case (it.command)
        CMD_SEND: begin
          t = tail_ptr % RING_MAX;
          if (it.data_valid) tail_count = store_byte(t, tail_count, it.data_byte);
          if (it.end_of_message) begin
            len_mem[t]  = LEN_W'(tail_count);
            len_seen[t] = 1'b1;
            tail_count  = 0;
            tail_ptr    = step_fwd(t);
          end
        end
        CMD_URGENT: begin
          if (!urgent_open) begin
            head_ptr     = step_back(h);
            urgent_open  = 1'b1;
            urgent_count = 0;
          end
          h = head_ptr % RING_MAX;
          if (it.data_valid) urgent_count = store_byte(h, urgent_count, it.data_byte);
          if (it.end_of_message) begin
            len_mem[h]   = LEN_W'(urgent_count);
            len_seen[h]  = 1'b1;
            urgent_count = 0;
            urgent_open  = 1'b0;
          end
        end
        default: begin
          stored = len_mem[h];
          if (stored > CAP_MAX) stored = CAP_MAX;
          copied = (it.max_len < stored) ? it.max_len : stored;
          r.stored_len = LEN_W'(stored);
          r.copied_len = LEN_W'(copied);
          if (it.command == CMD_GET_LEN || copied == 0) begin
            r.out_byte  = '0;
            r.out_valid = 1'b0;
            r.out_last  = 1'b1;
            due_results.push_back(r);
          end else begin
            for (int unsigned k = 0; k < copied; k++) begin
              r.out_byte  = slot_mem[h][k];
              r.out_valid = 1'b1;
              r.out_last  = (k + 1 == copied);
              due_results.push_back(r);
            end
          end
          if (it.command == CMD_GET) head_ptr = step_fwd(h);
        end
      endcase
    endfunction

    function void check_delivery(msd_out_t got);
      msd_out_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: out_byte %0d out_last %0d", got.out_byte, got.out_last);
        failures++;
        return;
      end
      want = due_results.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte mismatch: expected %0d, actual %0d", want.out_byte, got.out_byte);
        failures++;
      end
      if (got.out_valid !== want.out_valid) begin
        $error("out_valid mismatch: expected %0d, actual %0d", want.out_valid, got.out_valid);
        failures++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last mismatch: expected %0d, actual %0d", want.out_last, got.out_last);
        failures++;
      end
      if (got.stored_len !== want.stored_len) begin
        $error("stored_len mismatch: expected %0d, actual %0d",
               want.stored_len, got.stored_len);
        failures++;
      end
      if (got.copied_len !== want.copied_len) begin
        $error("copied_len mismatch: expected %0d, actual %0d",
               want.copied_len, got.copied_len);
        failures++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  msd_in_t               cmd_item    = '0;
  msd_out_t              result;
  logic                  strobe;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  reg_idx_e              cfg_index   = REG_SLOT_BYTES;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  deque_scoreboard sb;
  int unsigned     items_sent  = 0;
  int unsigned     burst_left  = 0;
  bit              gaps_on     = 1'b1;
  int unsigned     stall_count = 0;

  message_slot_deque_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (cmd_item),
    .result_o    (result),
    .strobe_o    (strobe),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe) sb.check_delivery(result);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic msd_in_t mk(cmd_e c, int unsigned b, bit v, bit eom, int unsigned ml);
    msd_in_t it;
    it.command        = c;
    it.data_byte      = BYTE_W'(b);
    it.data_valid     = v;
    it.end_of_message = eom;
    it.max_len        = LEN_W'(ml);
    return it;
  endfunction

  // A read of the head slot needs its length and the bytes it copies written;
  // with no length it becomes a harmless byte, else max_len is cut to fit.
  function automatic msd_in_t guard_read(msd_in_t it);
    int unsigned h;
    int unsigned stored;
    int unsigned room;
    h = sb.head_ptr % RING_MAX;
    if (!sb.len_seen[h]) return mk(CMD_SEND, $urandom_range(0, 255), 1'b1, 1'b0, 0);
    if (it.command == CMD_GET) begin
      stored = sb.len_mem[h];
      if (stored > CAP_MAX) stored = CAP_MAX;
      room = sb.readable_prefix(h);
      if (((it.max_len < stored) ? it.max_len : stored) > room) begin
        it.max_len = LEN_W'($urandom_range(0, room));
      end
    end
    return it;
  endfunction

  task automatic issue(msd_in_t it);
    if (gaps_on && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    start    <= 1'b1;
    cmd_item <= it;
    do @(posedge clk_i); while (busy);
    sb.apply_command(it);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic issue_read(cmd_e c, int unsigned ml);
    issue(guard_read(mk(c, $urandom_range(0, 255), $urandom_range(0, 1), 1'b0, ml)));
  endtask

  task automatic send_message(cmd_e c, int unsigned len, bit with_gets);
    if (len == 0) begin
      issue(mk(c, $urandom_range(0, 255), 1'b0, 1'b1, $urandom_range(0, 64)));
    end
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        issue(mk(c, $urandom_range(0, 255), 1'b0, 1'b0, $urandom_range(0, 64)));
      end
      if (with_gets && $urandom_range(0, 5) == 0) issue_read(CMD_GET, $urandom_range(0, 64));
      issue(mk(c, $urandom_range(0, 255), 1'b1, k + 1 == len, $urandom_range(0, 64)));
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned target;
    int unsigned pick;
    int unsigned lim;
    msd_in_t     noise;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      lim  = sb.eff_cap() + 2;
      if (lim > 6 && $urandom_range(0, 7) != 0) lim = 6;
      if (pick < 40) begin
        send_message(CMD_SEND, $urandom_range(0, lim), 1'b0);
      end else if (pick < 55) begin
        send_message(CMD_URGENT, $urandom_range(0, lim), 1'b1);
      end else if (pick < 80) begin
        issue_read(CMD_GET, $urandom_range(0, 64));
      end else if (pick < 90) begin
        issue_read(CMD_GET_LEN, $urandom_range(0, 64));
      end else begin
        noise = mk(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                   $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 64));
        if (noise.command == CMD_GET || noise.command == CMD_GET_LEN) noise = guard_read(noise);
        issue(noise);
      end
    end
  endtask

  task automatic configure(int unsigned cap, int unsigned ring);
    start <= 1'b0;
    while (sb.due_results.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SLOT_BYTES;
    cfg_data  <= CFG_DATA_W'(cap);
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(REG_SLOT_BYTES, CFG_DATA_W'(cap));
    cfg_index <= REG_SLOTS_IN_USE;
    cfg_data  <= CFG_DATA_W'(ring);
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(REG_SLOTS_IN_USE, CFG_DATA_W'(ring));
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(mk(CMD_SEND, 8'h00, 1'b0, 1'b1, 0));
    issue(mk(CMD_SEND, 8'h00, 1'b1, 1'b0, 0));
    issue(mk(CMD_SEND, 8'hFF, 1'b1, 1'b0, 0));
    issue(mk(CMD_SEND, 8'hA5, 1'b1, 1'b0, 0));
    issue(mk(CMD_SEND, 8'h5A, 1'b1, 1'b1, 0));
    issue_read(CMD_GET_LEN, 64);
    issue_read(CMD_GET, 64);
    issue_read(CMD_GET, 2);
    issue(mk(CMD_URGENT, 8'h11, 1'b1, 1'b0, 0));
    issue(mk(CMD_URGENT, 8'h22, 1'b1, 1'b1, 0));
    issue_read(CMD_GET_LEN, 0);
    issue_read(CMD_GET, 64);
    issue(mk(CMD_SEND, 8'h77, 1'b1, 1'b0, 0));
    issue(mk(CMD_SEND, 8'h3C, 1'b0, 1'b0, 0));
    issue(mk(CMD_SEND, 8'h88, 1'b1, 1'b1, 0));
    issue_read(CMD_GET, 0);
    issue(mk(CMD_URGENT, 8'h00, 1'b0, 1'b1, 64));
    issue_read(CMD_GET, 64);
    // An urgent message cut in two by a get: the second byte follows the head.
    issue(mk(CMD_URGENT, 8'h33, 1'b1, 1'b0, 0));
    issue_read(CMD_GET, 64);
    issue(mk(CMD_URGENT, 8'h44, 1'b1, 1'b1, 0));
    issue_read(CMD_GET_LEN, 64);
    issue_read(CMD_GET, 64);

    configure(0, 0);
    run_random(20);
    configure(127, 31);
    run_random(20);
    configure(3, 4);
    run_random(25);
    configure(1, 1);
    run_random(15);
    gaps_on = 1'b0;
    configure(64, 16);
    run_random(25);
    gaps_on = 1'b1;
    configure($urandom_range(1, 64), $urandom_range(1, 16));
    run_random(25);

    start <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && sb.due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
hdl/msd_pkg.sv
hdl/msd_ctrl.sv
hdl/msd_datapath.sv
hdl/message_slot_deque_top.sv
bench/message_slot_deque_top_tb.sv
